FILE: rtl/arpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ARP cache responder.
// No dependencies; imported by arpc_cell and arp_cache_responder.
package arpc_pkg;

   localparam int ENTRIES_DEFAULT = 16;

   localparam int IP_W  = 32;
   localparam int MAC_W = 48;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_IP  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_MAC = 1'b1;

   // ARP operation codes on the request side
   localparam logic [1:0] OPER_REQUEST = 2'd0;
   localparam logic [1:0] OPER_REPLY   = 2'd1;

   // what a token moving down the cell row is doing
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_LEARN  = 2'd2;
   localparam logic [1:0] KIND_REPLY  = 2'd3;

   typedef struct packed {
      logic             valid;
      logic [1:0]       kind;
      logic             done;     // learn: stored, lookup: hit
      logic [IP_W-1:0]  ip;       // sender / queried IP
      logic [MAC_W-1:0] mac;      // sender MAC, or found MAC after a hit
      logic [MAC_W-1:0] src_mac;  // frame source for replies
   } token_type;

endpackage

FILE: rtl/arpc_cell.sv
`timescale 1ns / 1ps
// One cache entry of the ARP table plus its stage of the token row.
// Depends on arpc_pkg (token_type, kind codes).
module arpc_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  arpc_pkg::token_type tok_in,
   output arpc_pkg::token_type tok_out
);
   import arpc_pkg::*;

   logic [IP_W-1:0]  ip_ff;
   logic [MAC_W-1:0] mac_ff;
   logic             valid_ff;
   token_type        tok_ff;
   token_type        tok_in_proc;
   logic             ip_eq;
   logic             do_hit;
   logic             do_learn;

   assign ip_eq    = (ip_ff == tok_in.ip);
   assign do_hit   = tok_in.valid && (tok_in.kind == KIND_LOOKUP) && !tok_in.done
                     && valid_ff && ip_eq;
   assign do_learn = tok_in.valid && (tok_in.kind == KIND_LEARN) && !tok_in.done
                     && (!valid_ff || ip_eq);

   always_comb begin
      tok_in_proc = tok_in;
      if (do_hit) begin
         tok_in_proc.done = 1'b1;
         tok_in_proc.mac  = mac_ff;
      end
      if (do_learn) begin
         tok_in_proc.done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (adv) begin
         tok_ff <= tok_in_proc;
         if (do_learn) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && do_learn) begin
         ip_ff  <= tok_in.ip;
         mac_ff <= tok_in.mac;
      end
   end

   assign tok_out = tok_ff;

endmodule

FILE: rtl/arp_cache_responder.sv
`timescale 1ns / 1ps
// ARP cache responder top level: input classification, cell row, result register.
// Depends on arpc_pkg and arpc_cell.
//
// Each transfer on req_ is an ARP message (tuser func = 0) or a lookup
// (func = 1), and yields exactly one transfer on rsp_. A request whose target
// IP equals own_ip gives a reply description; a reply is learned into the
// first entry that is free or already holds its IP, else table_full is set;
// a lookup returns the MAC of the first valid matching entry. The table is a
// row of ENTRIES cells, one entry each; an item travels down the row one cell
// per clock unless the row stalls, and its result is then registered.
// req_tready comes back in the same cycle that rsp_tvalid rises, so the next
// item can be accepted in that cycle; only one item is in the row at a time.
// The result register lets the next item enter while a result waits on
// rsp_tready; that item stalls only when it reaches the end of the row with
// the older result still waiting.
// All entries are invalid after reset; no clearing pass is needed. Write
// csr_ only while idle. Register 0 is own_ip; register 1 (own_mac) is the
// reply sender address used by the transmit side and carries nothing here.
module arp_cache_responder #(
   parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_wen,
   input  logic [arpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [arpc_pkg::MAC_W-1:0]     csr_wdata,
   // requests
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [31:0] sender_ip, [79:32] sender_mac, [111:80] tgt_ip,
   // [159:112] frame_src_mac
   input  logic [159:0]                   req_tdata,
   // [0] func, [2:1] arp_oper
   input  logic [2:0]                     req_tuser,
   // results
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [47:0] reply_dest_mac, [95:48] reply_target_mac,
   // [127:96] reply_tgt_ip, [175:128] found_mac
   output logic [175:0]                   rsp_tdata,
   // [0] reply_valid, [1] learned, [2] table_full, [3] hit
   output logic [3:0]                     rsp_tuser
);
   import arpc_pkg::*;

   // ---------------- configuration ----------------
   logic [IP_W-1:0] own_ip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff <= 32'hC0A8_0101;
      end else if (csr_wen && (csr_index == CSR_OWN_IP)) begin
         own_ip_ff <= csr_wdata[IP_W-1:0];
      end
   end

   // ---------------- input unpack ----------------
   logic             in_func;
   logic [1:0]       in_oper;
   logic [IP_W-1:0]  in_sip;
   logic [MAC_W-1:0] in_smac;
   logic [IP_W-1:0]  in_tip;
   logic [MAC_W-1:0] in_fsrc;

   assign in_func = req_tuser[0];
   assign in_oper = req_tuser[2:1];
   assign in_sip  = req_tdata[31:0];
   assign in_smac = req_tdata[79:32];
   assign in_tip  = req_tdata[111:80];
   assign in_fsrc = req_tdata[159:112];

   // ---------------- control ----------------
   logic busy_ff, busy_in;     // an item is in the row
   logic req_xfer;
   logic adv;                  // row moves this cycle
   logic load_rsp;

   token_type tok_first;
   token_type tok [ENTRIES];
   token_type tok_last;
   logic [ENTRIES-1:0] tok_valid;

   assign req_tready = !busy_ff;
   assign req_xfer   = req_tvalid && req_tready;

   // classify once on entry; the reply decision needs no table access
   always_comb begin
      tok_first         = '0;
      tok_first.valid   = req_xfer;
      tok_first.ip      = in_sip;
      tok_first.mac     = in_smac;
      tok_first.src_mac = in_fsrc;
      if (in_func) begin
         tok_first.kind = KIND_LOOKUP;
      end else if (in_oper == OPER_REQUEST) begin
         tok_first.kind = (in_tip == own_ip_ff) ? KIND_REPLY : KIND_NONE;
      end else if (in_oper == OPER_REPLY) begin
         tok_first.kind = KIND_LEARN;
      end else begin
         tok_first.kind = KIND_NONE;
      end
   end

   // ---------------- cell row ----------------
   genvar gi;
   generate
      for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            arpc_cell u_cell (
               .clock   (clock),
               .reset   (reset),
               .adv     (adv),
               .tok_in  (tok_first),
               .tok_out (tok[gi])
            );
         end else begin : g_body
            arpc_cell u_cell (
               .clock   (clock),
               .reset   (reset),
               .adv     (adv),
               .tok_in  (tok[gi-1]),
               .tok_out (tok[gi])
            );
         end
         assign tok_valid[gi] = tok[gi].valid;
      end
   endgenerate

   assign tok_last = tok[ENTRIES-1];

   // the row only stalls when its finished item cannot enter the result register
   assign adv      = !(tok_last.valid && rsp_tvalid && !rsp_tready);
   assign load_rsp = tok_last.valid && adv;

   always_comb begin
      busy_in = busy_ff;
      if (load_rsp) begin
         busy_in = 1'b0;
      end
      if (req_xfer) begin
         busy_in = 1'b1;
      end
   end

   // ---------------- result register ----------------
   logic         rsp_valid_ff, rsp_valid_in;
   logic [175:0] rsp_data_ff, rsp_data_in;
   logic [3:0]   rsp_user_ff, rsp_user_in;
   logic         is_reply;
   logic         is_hit;

   assign is_reply = (tok_last.kind == KIND_REPLY);
   assign is_hit   = (tok_last.kind == KIND_LOOKUP) && tok_last.done;

   always_comb begin
      rsp_data_in            = '0;
      rsp_data_in[47:0]      = is_reply ? tok_last.src_mac : '0;
      rsp_data_in[95:48]     = is_reply ? tok_last.mac : '0;
      rsp_data_in[127:96]    = is_reply ? tok_last.ip : '0;
      rsp_data_in[175:128]   = is_hit ? tok_last.mac : '0;
      rsp_user_in[0]         = is_reply;
      rsp_user_in[1]         = (tok_last.kind == KIND_LEARN) && tok_last.done;
      rsp_user_in[2]         = (tok_last.kind == KIND_LEARN) && !tok_last.done;
      rsp_user_in[3]         = is_hit;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------- assertions ----------------
   // idle means the row is empty
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (tok_valid == '0))
      else $error("token in cell row while idle");

   // one item at a time
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid))
      else $error("more than one token in cell row");

   // an accepted item occupies the row on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (busy_ff && tok_valid[0]))
      else $error("accepted item did not enter the row");

   // at most one outcome flag per result
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tuser))
      else $error("conflicting result flags");

endmodule
